// File: hdl/row_lane_centre_finder_assert.svh
// Assertion macros shared by the row lane centre finder modules.
`ifndef ROW_LANE_CENTRE_FINDER_ASSERT_SVH
`define ROW_LANE_CENTRE_FINDER_ASSERT_SVH

`ifndef SYNTHESIS
`define RLCF_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define RLCF_ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
`else
`define RLCF_ASSERT(label, prop, msg)
`define RLCF_ASSERT_IMPL(label, ante, cons, msg)
`endif

`endif

// File: hdl/rlcf_pkg.sv
// Types and constants shared by the row lane centre finder.
package rlcf_pkg;

  localparam int OUT_W = 11;

  localparam logic [1:0] ST_OK         = 2'd0;
  localparam logic [1:0] ST_NO_LINES   = 2'd1;
  localparam logic [1:0] ST_MANY_LINES = 2'd2;

  typedef struct packed {
    logic [OUT_W-1:0] centre;
    logic [OUT_W-1:0] lines;
    logic [1:0]       status;
  } result_t;

endpackage

// File: hdl/rlcf_row_scan.sv
// Row scan state: transitions, segment midpoints, held centre and row result.
module rlcf_row_scan #(
  parameter int MAX_WIDTH = 2048
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              take,
  input  logic              px_bit,
  input  logic              row_end,
  output rlcf_pkg::result_t res
);

  localparam int CW  = $clog2(MAX_WIDTH + 1);
  localparam int XW  = (MAX_WIDTH > 2) ? $clog2(MAX_WIDTH) : 1;
  localparam int LW  = (XW + 1 > rlcf_pkg::OUT_W) ? XW + 1 : rlcf_pkg::OUT_W;
  localparam int CNW = (CW > rlcf_pkg::OUT_W) ? CW : rlcf_pkg::OUT_W;

  logic [CW-1:0] col_r, col_nxt;
  logic          prev_r, prev_nxt;
  logic [XW-1:0] tc_r, tc_nxt;
  logic [XW-1:0] seg_r, seg_nxt;
  logic [XW-1:0] fms_r, fms_nxt;
  logic [XW-1:0] fmp_r, fmp_nxt;
  logic [XW-1:0] smid_r, smid_nxt;
  logic [rlcf_pkg::OUT_W-1:0] held_r, held_nxt;

  logic [XW-1:0]   col_idx;
  logic [XW+1:0]   tc_w;
  logic [XW-1:0]   mid;
  logic [LW-1:0]   lines;
  logic [CNW-1:0]  c1, c2, centre;
  logic            good;

  always_comb begin
    col_nxt  = col_r;
    prev_nxt = prev_r;
    tc_nxt   = tc_r;
    seg_nxt  = seg_r;
    fms_nxt  = fms_r;
    fmp_nxt  = fmp_r;
    smid_nxt = smid_r;
    col_idx  = col_r[XW-1:0];
    tc_w     = (XW+2)'(tc_r);
    mid      = XW'(((XW+1)'(seg_r) + (XW+1)'(col_idx)) >> 1);

    if (col_r < CW'(MAX_WIDTH)) begin
      if ((col_r != '0) && (px_bit != prev_r)) begin
        case (tc_w)
          (XW+2)'(0): begin
            seg_nxt = col_idx;
            fmp_nxt = col_idx;
          end
          (XW+2)'(1): begin
            fms_nxt = mid;
            fmp_nxt = mid;
          end
          (XW+2)'(2): begin
            seg_nxt  = col_idx;
            smid_nxt = col_idx;
          end
          (XW+2)'(3): begin
            smid_nxt = mid;
          end
          default: begin
          end
        endcase
        tc_nxt = tc_r + XW'(1);
      end
      prev_nxt = px_bit;
      col_nxt  = col_r + CW'(1);
    end

    // result from the state after this pixel
    lines = LW'(((XW+1)'(tc_nxt) + (XW+1)'(1)) >> 1);
    if ((CW+1)'(fms_nxt) >= (CW+1)'(col_nxt >> 1)) begin
      c1 = CNW'(fms_nxt >> 1);
    end else begin
      c1 = CNW'(((CW+1)'(fms_nxt) + (CW+1)'(col_nxt)) >> 1);
    end
    c2 = CNW'(((XW+1)'(fmp_nxt) + (XW+1)'(smid_nxt)) >> 1);

    good       = 1'b1;
    centre     = c1;
    res.status = rlcf_pkg::ST_OK;
    if (lines == LW'(1)) begin
      centre = c1;
    end else if (lines == LW'(2)) begin
      centre = c2;
    end else begin
      good       = 1'b0;
      res.status = (lines == '0) ? rlcf_pkg::ST_NO_LINES : rlcf_pkg::ST_MANY_LINES;
    end
    res.centre = good ? centre[rlcf_pkg::OUT_W-1:0] : held_r;
    res.lines  = lines[rlcf_pkg::OUT_W-1:0];

    held_nxt = held_r;
    if (take && row_end) begin
      held_nxt = res.centre;
      col_nxt  = '0;
      prev_nxt = 1'b0;
      tc_nxt   = '0;
      seg_nxt  = '0;
      fms_nxt  = '0;
      fmp_nxt  = '0;
      smid_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r  <= '0;
      prev_r <= 1'b0;
      tc_r   <= '0;
      seg_r  <= '0;
      fms_r  <= '0;
      fmp_r  <= '0;
      smid_r <= '0;
      held_r <= '0;
    end else if (take) begin
      col_r  <= col_nxt;
      prev_r <= prev_nxt;
      tc_r   <= tc_nxt;
      seg_r  <= seg_nxt;
      fms_r  <= fms_nxt;
      fmp_r  <= fmp_nxt;
      smid_r <= smid_nxt;
      held_r <= held_nxt;
    end
  end

`include "row_lane_centre_finder_assert.svh"

  `RLCF_ASSERT(a_col_bound, col_r <= CW'(MAX_WIDTH), "column count past row limit")
  `RLCF_ASSERT_IMPL(a_tc_below_col, col_r != '0, (CW+1)'(tc_r) < (CW+1)'(col_r), "transitions not below columns")
  `RLCF_ASSERT(a_row_clear, take && row_end |=> col_r == '0 && tc_r == '0, "row state not cleared at row end")

endmodule

// File: hdl/row_lane_centre_finder.sv
// Row lane centre finder top level: input register, row scan and result register.
//
//   channel | ports                                          | dir
//   --------+------------------------------------------------+-----
//   in      | in_valid in_ready in_pixel in_row_end          | in
//   out     | out_valid out_ready out_lane_centre            | out
//           |   out_line_count out_status                    |
//
// One pixel per clock while no row-end pixel waits on a held result; out_valid is registered
// as the row-end pixel leaves the input register, and the rate is set by the row scan update.
// Synchronous active-low reset clears the row state, the held centre and both valid flags.
// A row-end pixel waits in the input register while an unaccepted result is held;
// other pixels keep flowing while the result waits.
module row_lane_centre_finder #(
  parameter int MAX_WIDTH = 2048
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_pixel,
  input  logic        in_row_end,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [10:0] out_lane_centre,
  output logic [10:0] out_line_count,
  output logic [1:0]  out_status
);

  logic              in_v_r, in_v_nxt;
  logic              in_bit_r;
  logic              in_end_r;
  logic              out_v_r, out_v_nxt;
  rlcf_pkg::result_t out_r;
  rlcf_pkg::result_t res;
  logic              adv;

  assign adv      = in_v_r && (!in_end_r || !out_v_r || out_ready);
  assign in_ready = !in_v_r || adv;

  always_comb begin
    in_v_nxt = in_v_r;
    if (in_ready) begin
      in_v_nxt = in_valid;
    end
    out_v_nxt = out_v_r;
    if (adv && in_end_r) begin
      out_v_nxt = 1'b1;
    end else if (out_ready) begin
      out_v_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r  <= 1'b0;
      out_v_r <= 1'b0;
    end else begin
      in_v_r  <= in_v_nxt;
      out_v_r <= out_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      in_bit_r <= in_pixel[0];
      in_end_r <= in_row_end;
    end
    if (adv && in_end_r) begin
      out_r <= res;
    end
  end

  rlcf_row_scan #(
    .MAX_WIDTH(MAX_WIDTH)
  ) u_scan (
    .clk    (clk),
    .rst_n  (rst_n),
    .take   (adv),
    .px_bit (in_bit_r),
    .row_end(in_end_r),
    .res    (res)
  );

  assign out_valid       = out_v_r;
  assign out_lane_centre = out_r.centre;
  assign out_line_count  = out_r.lines;
  assign out_status      = out_r.status;

`include "row_lane_centre_finder_assert.svh"

  `RLCF_ASSERT_IMPL(a_end_blocks, in_v_r && in_end_r && out_v_r && !out_ready, !in_ready, "row end passed a held result")
  `RLCF_ASSERT(a_end_gives_result, adv && in_end_r |=> out_v_r, "row end gave no result")
  `RLCF_ASSERT_IMPL(a_no_lines_count, out_v_r && out_r.status == rlcf_pkg::ST_NO_LINES, out_r.lines == '0, "no-line status with lines")

endmodule
